@@ hw/rtl/rgbfx_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RGB LED effect generator package
// Shared widths, register indexes, reset values and field codes.
// ----------------------------------------------------------------------------
package rgbfx_pkg;

    localparam int COLOR_W  = 8;
    localparam int PERIOD_W = 16;
    localparam int MODE_W   = 2;
    localparam int LEVEL_W  = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 8;

    localparam logic OP_TICK    = 1'b0;
    localparam logic OP_COMMAND = 1'b1;

    localparam logic [MODE_W-1:0] MODE_OFF     = 2'd0;
    localparam logic [MODE_W-1:0] MODE_SOLID   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_BLINK   = 2'd2;
    localparam logic [MODE_W-1:0] MODE_BREATHE = 2'd3;

    localparam logic [LEVEL_W-1:0] LEVEL_DEFAULT = 2'd0;
    localparam logic [LEVEL_W-1:0] LEVEL_LOW     = 2'd1;
    localparam logic [LEVEL_W-1:0] LEVEL_MEDIUM  = 2'd2;
    localparam logic [LEVEL_W-1:0] LEVEL_HIGH    = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_LOW_BRIGHTNESS     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MEDIUM_BRIGHTNESS  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HIGH_BRIGHTNESS    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DEFAULT_BRIGHTNESS = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_GLOBAL_LEVEL       = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_INTERVAL     = 3'd5;

    localparam logic [COLOR_W-1:0]  LOW_BRIGHTNESS_RST     = 8'd64;
    localparam logic [COLOR_W-1:0]  MEDIUM_BRIGHTNESS_RST  = 8'd128;
    localparam logic [COLOR_W-1:0]  HIGH_BRIGHTNESS_RST    = 8'd255;
    localparam logic [COLOR_W-1:0]  DEFAULT_BRIGHTNESS_RST = 8'd128;
    localparam logic [COLOR_W-1:0]  FRAME_INTERVAL_RST     = 8'd20;
    localparam logic [PERIOD_W-1:0] PERIOD_RST             = 16'd1000;

endpackage

@@ hw/rtl/rgbfx_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RGB LED effect generator channels
// Valid/ready channels for input items and rendered frames.
// ----------------------------------------------------------------------------
interface rgbfx_in_if;
    logic                                valid;
    logic                                ready;
    logic                                op;
    logic [rgbfx_pkg::MODE_W-1:0]        mode;
    logic [rgbfx_pkg::COLOR_W-1:0]       red;
    logic [rgbfx_pkg::COLOR_W-1:0]       green;
    logic [rgbfx_pkg::COLOR_W-1:0]       blue;
    logic [rgbfx_pkg::PERIOD_W-1:0]      period_len;
    logic [rgbfx_pkg::LEVEL_W-1:0]       level;

    modport source (output valid, op, mode, red, green, blue, period_len, level,
                    input ready);
    modport sink (input valid, op, mode, red, green, blue, period_len, level,
                  output ready);
endinterface

interface rgbfx_out_if;
    logic                                valid;
    logic                                ready;
    logic [rgbfx_pkg::MODE_W-1:0]        frame_mode;
    logic [rgbfx_pkg::COLOR_W-1:0]       out_red;
    logic [rgbfx_pkg::COLOR_W-1:0]       out_green;
    logic [rgbfx_pkg::COLOR_W-1:0]       out_blue;
    logic [rgbfx_pkg::COLOR_W-1:0]       strip_brightness;

    modport source (output valid, frame_mode, out_red, out_green, out_blue,
                    strip_brightness, input ready);
    modport sink (input valid, frame_mode, out_red, out_green, out_blue,
                  strip_brightness, output ready);
endinterface

@@ hw/rtl/rgb_led_effect_generator_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RGB LED effect generator
// Renders off, solid, blink and breathe frames from commands and 1 ms ticks.
// ----------------------------------------------------------------------------
// A command, or a tick that renders no frame, is taken while the block is idle.
// A tick that renders a frame stalls the input while it runs the bit-serial
// divider that forms the breathe wave (breathe with a period of two or more
// only), then the bit-serial multipliers that scale the three channels, and
// then moves the frame into the output register. That move waits while an
// earlier frame still sits untaken in the output register, and the input stays
// stalled for as long. The frame then waits in that register while further
// items are taken. Configuration writes are taken in every cycle.
module rgb_led_effect_generator_unit (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    rgbfx_in_if.sink                           i_in,
    rgbfx_out_if.source                        o_out,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [rgbfx_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [rgbfx_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_MUL,
        ST_DONE
    } t_state;

    localparam int CW = rgbfx_pkg::COLOR_W;
    localparam int PW = rgbfx_pkg::PERIOD_W;
    localparam int MW = rgbfx_pkg::MODE_W;
    localparam int LW = rgbfx_pkg::LEVEL_W;

    t_state r_state, n_state;

    logic [CW-1:0] r_low_bright, n_low_bright;
    logic [CW-1:0] r_med_bright, n_med_bright;
    logic [CW-1:0] r_high_bright, n_high_bright;
    logic [CW-1:0] r_def_bright, n_def_bright;
    logic [LW-1:0] r_global_level, n_global_level;
    logic [CW-1:0] r_frame_interval, n_frame_interval;

    logic [MW-1:0] r_mode, n_mode;
    logic [CW-1:0] r_red, n_red;
    logic [CW-1:0] r_green, n_green;
    logic [CW-1:0] r_blue, n_blue;
    logic [PW-1:0] r_period, n_period;
    logic [LW-1:0] r_level, n_level;
    logic [PW-1:0] r_phase, n_phase;
    logic [CW-1:0] r_frame_count, n_frame_count;

    logic [MW-1:0] r_w_mode, n_w_mode;
    logic [CW-1:0] r_w_red, n_w_red;
    logic [CW-1:0] r_w_green, n_w_green;
    logic [CW-1:0] r_w_blue, n_w_blue;
    logic [CW-1:0] r_w_bright, n_w_bright;
    logic [PW-1:0] r_rem, n_rem;
    logic [CW-1:0] r_num_lo, n_num_lo;
    logic [PW-1:0] r_den, n_den;
    logic [CW-1:0] r_quo, n_quo;
    logic [2:0]    r_cnt, n_cnt;
    logic [2*CW-1:0] r_acc_red, n_acc_red;
    logic [2*CW-1:0] r_acc_green, n_acc_green;
    logic [2*CW-1:0] r_acc_blue, n_acc_blue;

    logic          r_out_valid, n_out_valid;
    logic [MW-1:0] r_out_mode, n_out_mode;
    logic [CW-1:0] r_out_red, n_out_red;
    logic [CW-1:0] r_out_green, n_out_green;
    logic [CW-1:0] r_out_blue, n_out_blue;
    logic [CW-1:0] r_out_bright, n_out_bright;

    logic              w_in_xfer;
    logic              w_due;
    logic [PW:0]       w_phase_next;
    logic [PW-2:0]     w_half;
    logic              w_rising;
    logic [PW-1:0]     w_span;
    logic [PW+CW-1:0]  w_num;
    logic [PW-1:0]     w_den;
    logic [LW-1:0]     w_lvl;
    logic [CW-1:0]     w_bright;
    logic [CW-1:0]     w_weight;
    logic              w_need_div;
    logic [PW:0]       w_trial;
    logic [PW:0]       w_diff;
    logic              w_out_free;

    function automatic logic [CW-1:0] div255(input logic [2*CW-1:0] x);
        logic [2*CW:0] s;
        s = {1'b0, x} + {{(CW+1){1'b0}}, x[2*CW-1:CW]} + {{(2*CW){1'b0}}, 1'b1};
        return s[2*CW-1:CW];
    endfunction

    function automatic logic [2*CW-1:0] mac_step(input logic [2*CW-1:0] acc,
                                                 input logic bit_in,
                                                 input logic [CW-1:0] v);
        return {acc[2*CW-2:0], 1'b0} + (bit_in ? {{CW{1'b0}}, v} : {(2*CW){1'b0}});
    endfunction

    assign i_in.ready = (r_state == ST_IDLE);
    assign w_in_xfer  = i_in.valid && i_in.ready;
    assign o_cfg_ready = 1'b1;
    assign w_out_free = !r_out_valid || o_out.ready;

    assign o_out.valid            = r_out_valid;
    assign o_out.frame_mode       = r_out_mode;
    assign o_out.out_red          = r_out_red;
    assign o_out.out_green        = r_out_green;
    assign o_out.out_blue         = r_out_blue;
    assign o_out.strip_brightness = r_out_bright;

    assign w_due        = ({1'b0, r_frame_count} + 9'd1) >= {1'b0, r_frame_interval};
    assign w_phase_next = {1'b0, r_phase} + {{PW{1'b0}}, 1'b1};
    assign w_half       = r_period[PW-1:1];
    assign w_rising     = r_phase < {1'b0, w_half};
    assign w_span       = w_rising ? r_phase : (r_period - r_phase);
    assign w_num        = {w_span, {CW{1'b0}}} - {{CW{1'b0}}, w_span};
    assign w_den        = w_rising ? {1'b0, w_half} : (r_period - {1'b0, w_half});
    assign w_lvl        = (r_level != rgbfx_pkg::LEVEL_DEFAULT) ? r_level : r_global_level;
    assign w_need_div   = (r_mode == rgbfx_pkg::MODE_BREATHE) && (w_half != '0);
    assign w_trial      = {r_rem, r_num_lo[CW-1]};
    assign w_diff       = w_trial - {1'b0, r_den};

    always_comb begin
        unique case (w_lvl)
            rgbfx_pkg::LEVEL_LOW:    w_bright = r_low_bright;
            rgbfx_pkg::LEVEL_MEDIUM: w_bright = r_med_bright;
            rgbfx_pkg::LEVEL_HIGH:   w_bright = r_high_bright;
            default:                 w_bright = r_def_bright;
        endcase
    end

    always_comb begin
        unique case (r_mode)
            rgbfx_pkg::MODE_OFF:   w_weight = '0;
            rgbfx_pkg::MODE_SOLID: w_weight = '1;
            rgbfx_pkg::MODE_BLINK: w_weight = w_rising ? '1 : '0;
            default:               w_weight = '1;
        endcase
    end

    always_comb begin
        n_state          = r_state;
        n_low_bright     = r_low_bright;
        n_med_bright     = r_med_bright;
        n_high_bright    = r_high_bright;
        n_def_bright     = r_def_bright;
        n_global_level   = r_global_level;
        n_frame_interval = r_frame_interval;
        n_mode           = r_mode;
        n_red            = r_red;
        n_green          = r_green;
        n_blue           = r_blue;
        n_period         = r_period;
        n_level          = r_level;
        n_phase          = r_phase;
        n_frame_count    = r_frame_count;
        n_w_mode         = r_w_mode;
        n_w_red          = r_w_red;
        n_w_green        = r_w_green;
        n_w_blue         = r_w_blue;
        n_w_bright       = r_w_bright;
        n_rem            = r_rem;
        n_num_lo         = r_num_lo;
        n_den            = r_den;
        n_quo            = r_quo;
        n_cnt            = r_cnt;
        n_acc_red        = r_acc_red;
        n_acc_green      = r_acc_green;
        n_acc_blue       = r_acc_blue;
        n_out_valid      = r_out_valid && !o_out.ready;
        n_out_mode       = r_out_mode;
        n_out_red        = r_out_red;
        n_out_green      = r_out_green;
        n_out_blue       = r_out_blue;
        n_out_bright     = r_out_bright;

        if (i_cfg_valid) begin
            unique case (i_cfg_index)
                rgbfx_pkg::REG_LOW_BRIGHTNESS:     n_low_bright = i_cfg_data;
                rgbfx_pkg::REG_MEDIUM_BRIGHTNESS:  n_med_bright = i_cfg_data;
                rgbfx_pkg::REG_HIGH_BRIGHTNESS:    n_high_bright = i_cfg_data;
                rgbfx_pkg::REG_DEFAULT_BRIGHTNESS: n_def_bright = i_cfg_data;
                rgbfx_pkg::REG_GLOBAL_LEVEL:       n_global_level = i_cfg_data[LW-1:0];
                rgbfx_pkg::REG_FRAME_INTERVAL:     n_frame_interval = i_cfg_data;
                default: ;
            endcase
        end

        unique case (r_state)
            ST_IDLE: begin
                if (w_in_xfer) begin
                    if (i_in.op == rgbfx_pkg::OP_COMMAND) begin
                        n_mode   = i_in.mode;
                        n_red    = i_in.red;
                        n_green  = i_in.green;
                        n_blue   = i_in.blue;
                        n_period = (i_in.period_len == '0) ? {{(PW-1){1'b0}}, 1'b1}
                                                           : i_in.period_len;
                        n_level  = i_in.level;
                        n_phase  = '0;
                    end else begin
                        n_frame_count = w_due ? '0 : r_frame_count + 8'd1;
                        n_phase = (w_phase_next >= {1'b0, r_period}) ? '0
                                                                     : w_phase_next[PW-1:0];
                        if (w_due) begin
                            n_w_mode   = r_mode;
                            n_w_red    = r_red;
                            n_w_green  = r_green;
                            n_w_blue   = r_blue;
                            n_w_bright = w_bright;
                            n_rem      = w_num[PW+CW-1:CW];
                            n_num_lo   = w_num[CW-1:0];
                            n_den      = w_den;
                            n_quo      = w_weight;
                            n_cnt      = '1;
                            n_acc_red   = '0;
                            n_acc_green = '0;
                            n_acc_blue  = '0;
                            n_state    = w_need_div ? ST_DIV : ST_MUL;
                        end
                    end
                end
            end
            ST_DIV: begin
                if (!w_diff[PW]) begin
                    n_rem = w_diff[PW-1:0];
                end else begin
                    n_rem = w_trial[PW-1:0];
                end
                n_quo    = {r_quo[CW-2:0], !w_diff[PW]};
                n_num_lo = {r_num_lo[CW-2:0], 1'b0};
                n_cnt    = r_cnt - 3'd1;
                if (r_cnt == '0) begin
                    n_state = ST_MUL;
                end
            end
            ST_MUL: begin
                n_acc_red   = mac_step(r_acc_red, r_quo[CW-1], r_w_red);
                n_acc_green = mac_step(r_acc_green, r_quo[CW-1], r_w_green);
                n_acc_blue  = mac_step(r_acc_blue, r_quo[CW-1], r_w_blue);
                n_quo       = {r_quo[CW-2:0], 1'b0};
                n_cnt       = r_cnt - 3'd1;
                if (r_cnt == '0) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (w_out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_mode   = r_w_mode;
                    n_out_red    = div255(r_acc_red);
                    n_out_green  = div255(r_acc_green);
                    n_out_blue   = div255(r_acc_blue);
                    n_out_bright = r_w_bright;
                    n_state      = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state          <= ST_IDLE;
            r_low_bright     <= rgbfx_pkg::LOW_BRIGHTNESS_RST;
            r_med_bright     <= rgbfx_pkg::MEDIUM_BRIGHTNESS_RST;
            r_high_bright    <= rgbfx_pkg::HIGH_BRIGHTNESS_RST;
            r_def_bright     <= rgbfx_pkg::DEFAULT_BRIGHTNESS_RST;
            r_global_level   <= rgbfx_pkg::LEVEL_DEFAULT;
            r_frame_interval <= rgbfx_pkg::FRAME_INTERVAL_RST;
            r_mode           <= rgbfx_pkg::MODE_OFF;
            r_red            <= '0;
            r_green          <= '0;
            r_blue           <= '0;
            r_period         <= rgbfx_pkg::PERIOD_RST;
            r_level          <= rgbfx_pkg::LEVEL_DEFAULT;
            r_phase          <= '0;
            r_frame_count    <= rgbfx_pkg::FRAME_INTERVAL_RST - 8'd1;
            r_out_valid      <= 1'b0;
        end else begin
            r_state          <= n_state;
            r_low_bright     <= n_low_bright;
            r_med_bright     <= n_med_bright;
            r_high_bright    <= n_high_bright;
            r_def_bright     <= n_def_bright;
            r_global_level   <= n_global_level;
            r_frame_interval <= n_frame_interval;
            r_mode           <= n_mode;
            r_red            <= n_red;
            r_green          <= n_green;
            r_blue           <= n_blue;
            r_period         <= n_period;
            r_level          <= n_level;
            r_phase          <= n_phase;
            r_frame_count    <= n_frame_count;
            r_out_valid      <= n_out_valid;
        end
        r_w_mode     <= n_w_mode;
        r_w_red      <= n_w_red;
        r_w_green    <= n_w_green;
        r_w_blue     <= n_w_blue;
        r_w_bright   <= n_w_bright;
        r_rem        <= n_rem;
        r_num_lo     <= n_num_lo;
        r_den        <= n_den;
        r_quo        <= n_quo;
        r_cnt        <= n_cnt;
        r_acc_red    <= n_acc_red;
        r_acc_green  <= n_acc_green;
        r_acc_blue   <= n_acc_blue;
        r_out_mode   <= n_out_mode;
        r_out_red    <= n_out_red;
        r_out_green  <= n_out_green;
        r_out_blue   <= n_out_blue;
        r_out_bright <= n_out_bright;
    end

`ifndef SYNTH
    a_phase_in_period: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase < r_period))
        else $error("Phase counter reached the effect period.");

    a_rem_below_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV) |-> (r_rem < r_den))
        else $error("Divider remainder is not below the divisor.");

    a_due_starts_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_xfer && (i_in.op == rgbfx_pkg::OP_TICK) && w_due) |=> (r_state != ST_IDLE))
        else $error("A due tick did not start a frame.");

    a_done_loads_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_DONE) && w_out_free) |=> (o_out.valid && (r_state == ST_IDLE)))
        else $error("A finished frame was not moved to the output register.");
`endif

endmodule

@@ sim/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RGB LED effect generator testbench
// Sends commands and millisecond ticks to the effect generator under random
// input gaps and output stalls. It keeps its own copy of the effect state and
// registers, works out every frame that a tick should render, and checks each
// frame transfer field by field against the oldest frame still owed.
// ----------------------------------------------------------------------------
module testbench;
    import rgbfx_pkg::*;

    localparam int     CLK_HALF_NS  = 5;
    localparam int     RESET_CYCLES = 6;
    localparam int     IDLE_SETTLE  = 24;
    localparam int     END_WAIT     = 20000;
    localparam int     RANDOM_ITEMS = 1100;
    localparam longint TIMEOUT_NS   = 10_000_000;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 3'd7;

    typedef struct packed {
        logic                op;
        logic [MODE_W-1:0]   mode;
        logic [COLOR_W-1:0]  red;
        logic [COLOR_W-1:0]  green;
        logic [COLOR_W-1:0]  blue;
        logic [PERIOD_W-1:0] period_len;
        logic [LEVEL_W-1:0]  level;
    } t_fx_item;

    typedef struct packed {
        logic [MODE_W-1:0]  frame_mode;
        logic [COLOR_W-1:0] out_red;
        logic [COLOR_W-1:0] out_green;
        logic [COLOR_W-1:0] out_blue;
        logic [COLOR_W-1:0] strip_brightness;
    } t_frame;

    typedef struct packed {
        logic [COLOR_W-1:0] low_value;
        logic [COLOR_W-1:0] medium_value;
        logic [COLOR_W-1:0] high_value;
        logic [COLOR_W-1:0] default_value;
        logic [LEVEL_W-1:0] global_level;
        logic [COLOR_W-1:0] frame_interval;
    } t_fx_settings;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    rgbfx_in_if  fx_in ();
    rgbfx_out_if fx_out ();

    rgb_led_effect_generator_unit DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (fx_in),
        .o_out       (fx_out),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // Register copy, starting from the reset values.
    logic [COLOR_W-1:0]  cfg_low      = LOW_BRIGHTNESS_RST;
    logic [COLOR_W-1:0]  cfg_medium   = MEDIUM_BRIGHTNESS_RST;
    logic [COLOR_W-1:0]  cfg_high     = HIGH_BRIGHTNESS_RST;
    logic [COLOR_W-1:0]  cfg_default  = DEFAULT_BRIGHTNESS_RST;
    logic [LEVEL_W-1:0]  cfg_global   = LEVEL_DEFAULT;
    logic [COLOR_W-1:0]  cfg_interval = FRAME_INTERVAL_RST;

    // Effect state copy, starting from the reset values.
    logic [MODE_W-1:0]   fx_mode      = MODE_OFF;
    logic [COLOR_W-1:0]  fx_red       = '0;
    logic [COLOR_W-1:0]  fx_green     = '0;
    logic [COLOR_W-1:0]  fx_blue      = '0;
    logic [PERIOD_W-1:0] fx_period    = PERIOD_RST;
    logic [LEVEL_W-1:0]  fx_level     = LEVEL_DEFAULT;
    logic [PERIOD_W-1:0] fx_phase     = '0;
    logic [COLOR_W-1:0]  fx_frame_cnt = FRAME_INTERVAL_RST - 8'd1;

    t_frame frames_due[$];

    int error_count     = 0;
    int frames_checked  = 0;
    int commands_sent   = 0;
    int ticks_sent      = 0;
    int settings_loaded = 0;
    int sink_hold_req   = 0;
    bit src_gaps_on     = 1'b1;
    bit sink_stalls_on  = 1'b1;

    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF_NS i_clk = ~i_clk;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("testbench: errors");
        $finish;
    end

    function automatic int idle_length();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 80) return $urandom_range(1, 3);
        if (r < 95) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [COLOR_W-1:0] pick_byte();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 12) return 8'h00;
        if (r < 24) return 8'hFF;
        return COLOR_W'($urandom_range(0, 255));
    endfunction

    function automatic logic [COLOR_W-1:0] breathe_weight(input logic [PERIOD_W-1:0] phase,
                                                          input logic [PERIOD_W-1:0] period);
        int unsigned ph;
        int unsigned per;
        int unsigned half;
        ph   = 32'(phase);
        per  = 32'(period);
        half = per / 2;
        if (per == 0 || half == 0) return 8'd255;
        if (ph >= per) ph = per - 1;
        if (ph < half) return COLOR_W'((ph * 255) / half);
        return COLOR_W'(((per - ph) * 255) / (per - half));
    endfunction

    function automatic logic [COLOR_W-1:0] scale_channel(input logic [COLOR_W-1:0] value,
                                                         input logic [COLOR_W-1:0] weight);
        int unsigned prod;
        prod = 32'(value);
        prod = prod * 32'(weight);
        return COLOR_W'(prod / 255);
    endfunction

    function automatic logic [COLOR_W-1:0] level_brightness(input logic [LEVEL_W-1:0] lvl);
        case (lvl)
            LEVEL_LOW:    return cfg_low;
            LEVEL_MEDIUM: return cfg_medium;
            LEVEL_HIGH:   return cfg_high;
            default:      return cfg_default;
        endcase
    endfunction

    // Updates the effect state for one accepted item and queues the frame it renders.
    function automatic void predict_frame(input t_fx_item item);
        t_frame              f;
        logic                due;
        logic [COLOR_W-1:0]  w;
        logic [LEVEL_W-1:0]  lvl;
        logic [PERIOD_W:0]   next_phase;
        if (item.op == OP_COMMAND) begin
            fx_mode   = item.mode;
            fx_red    = item.red;
            fx_green  = item.green;
            fx_blue   = item.blue;
            fx_period = (item.period_len == '0) ? 16'd1 : item.period_len;
            fx_level  = item.level;
            fx_phase  = '0;
            return;
        end
        due = ({1'b0, fx_frame_cnt} + 9'd1) >= {1'b0, cfg_interval};
        fx_frame_cnt = due ? 8'd0 : fx_frame_cnt + 8'd1;
        if (due) begin
            f.frame_mode = fx_mode;
            f.out_red    = fx_red;
            f.out_green  = fx_green;
            f.out_blue   = fx_blue;
            case (fx_mode)
                MODE_OFF: begin
                    f.out_red   = '0;
                    f.out_green = '0;
                    f.out_blue  = '0;
                end
                MODE_SOLID: begin
                end
                MODE_BLINK: begin
                    if (!(fx_phase < fx_period / 2)) begin
                        f.out_red   = '0;
                        f.out_green = '0;
                        f.out_blue  = '0;
                    end
                end
                default: begin
                    w = breathe_weight(fx_phase, fx_period);
                    f.out_red   = scale_channel(fx_red, w);
                    f.out_green = scale_channel(fx_green, w);
                    f.out_blue  = scale_channel(fx_blue, w);
                end
            endcase
            lvl = (fx_level != LEVEL_DEFAULT) ? fx_level : cfg_global;
            f.strip_brightness = level_brightness(lvl);
            frames_due.push_back(f);
        end
        next_phase = {1'b0, fx_phase} + 17'd1;
        if (next_phase >= {1'b0, fx_period}) next_phase = '0;
        fx_phase = next_phase[PERIOD_W-1:0];
    endfunction

    function automatic t_fx_item make_command(input logic [MODE_W-1:0]   mode,
                                              input logic [COLOR_W-1:0]  red,
                                              input logic [COLOR_W-1:0]  green,
                                              input logic [COLOR_W-1:0]  blue,
                                              input logic [PERIOD_W-1:0] period,
                                              input logic [LEVEL_W-1:0]  level);
        t_fx_item item;
        item.op         = OP_COMMAND;
        item.mode       = mode;
        item.red        = red;
        item.green      = green;
        item.blue       = blue;
        item.period_len = period;
        item.level      = level;
        return item;
    endfunction

    // Tick fields other than op are ignored by the block, so they carry noise.
    function automatic t_fx_item make_tick();
        t_fx_item item;
        item = make_command(MODE_W'($urandom_range(0, 3)), COLOR_W'($urandom_range(0, 255)),
                            COLOR_W'($urandom_range(0, 255)),
                            COLOR_W'($urandom_range(0, 255)),
                            PERIOD_W'($urandom_range(0, 65535)),
                            LEVEL_W'($urandom_range(0, 3)));
        item.op = OP_TICK;
        return item;
    endfunction

    function automatic t_fx_item random_command();
        logic [PERIOD_W-1:0] period;
        int unsigned         r;
        r = $urandom_range(0, 99);
        if (r < 30) period = PERIOD_W'($urandom_range(1, 8));
        else if (r < 60) period = PERIOD_W'($urandom_range(9, 64));
        else if (r < 67) period = 16'd0;
        else if (r < 74) period = 16'd1;
        else if (r < 80) period = 16'hFFFF;
        else period = PERIOD_W'($urandom_range(0, 65535));
        return make_command(MODE_W'($urandom_range(0, 3)), pick_byte(), pick_byte(),
                            pick_byte(), period, LEVEL_W'($urandom_range(0, 3)));
    endfunction

    function automatic t_fx_settings random_settings(input int phase);
        t_fx_settings s;
        int unsigned  r;
        if (phase == 0) return '{8'hFF, 8'hFF, 8'hFF, 8'hFF, LEVEL_HIGH, 8'd1};
        if (phase == 1) return '{8'h00, 8'h00, 8'h00, 8'h00, LEVEL_DEFAULT, 8'd2};
        s.low_value     = pick_byte();
        s.medium_value  = pick_byte();
        s.high_value    = pick_byte();
        s.default_value = pick_byte();
        s.global_level  = LEVEL_W'($urandom_range(0, 3));
        r = $urandom_range(0, 99);
        if (r < 70) s.frame_interval = COLOR_W'($urandom_range(1, 4));
        else if (r < 95) s.frame_interval = COLOR_W'($urandom_range(5, 12));
        else s.frame_interval = COLOR_W'($urandom_range(13, 40));
        return s;
    endfunction

    // Valid is left high after a transfer; the next call either replaces the
    // item or lowers valid for a gap, so valid never gets two updates in one step.
    task automatic send_item(input t_fx_item item);
        int gap;
        gap = 0;
        if (src_gaps_on && $urandom_range(0, 99) >= 60) gap = idle_length();
        if (gap > 0) begin
            fx_in.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        fx_in.valid      <= 1'b1;
        fx_in.op         <= item.op;
        fx_in.mode       <= item.mode;
        fx_in.red        <= item.red;
        fx_in.green      <= item.green;
        fx_in.blue       <= item.blue;
        fx_in.period_len <= item.period_len;
        fx_in.level      <= item.level;
        @(posedge i_clk);
        while (fx_in.ready !== 1'b1) @(posedge i_clk);
        predict_frame(item);
        if (item.op == OP_COMMAND) commands_sent++;
        else ticks_sent++;
    endtask

    task automatic wait_frames_drained();
        fx_in.valid <= 1'b0;
        do @(posedge i_clk); while (frames_due.size() != 0);
    endtask

    task automatic wait_block_idle();
        wait_frames_drained();
        repeat (IDLE_SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] index,
                             input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (o_cfg_ready !== 1'b1) @(posedge i_clk);
        case (index)
            REG_LOW_BRIGHTNESS:     cfg_low      = data;
            REG_MEDIUM_BRIGHTNESS:  cfg_medium   = data;
            REG_HIGH_BRIGHTNESS:    cfg_high     = data;
            REG_DEFAULT_BRIGHTNESS: cfg_default  = data;
            REG_GLOBAL_LEVEL:       cfg_global   = data[LEVEL_W-1:0];
            REG_FRAME_INTERVAL:     cfg_interval = data;
            default: begin
            end
        endcase
    endtask

    task automatic apply_settings(input t_fx_settings s);
        wait_block_idle();
        write_reg(REG_LOW_BRIGHTNESS, s.low_value);
        write_reg(REG_MEDIUM_BRIGHTNESS, s.medium_value);
        write_reg(REG_HIGH_BRIGHTNESS, s.high_value);
        write_reg(REG_DEFAULT_BRIGHTNESS, s.default_value);
        write_reg(REG_GLOBAL_LEVEL, {{(CFG_DATA_W-LEVEL_W){1'b0}}, s.global_level});
        write_reg(REG_FRAME_INTERVAL, s.frame_interval);
        i_cfg_valid <= 1'b0;
        settings_loaded++;
    endtask

    task automatic test_reset_frame();
        send_item(make_tick());
    endtask

    task automatic test_render_modes();
        apply_settings('{8'd0, 8'd255, 8'd1, 8'd200, LEVEL_LOW, 8'd1});
        send_item(make_command(MODE_SOLID, 8'hFF, 8'h00, 8'hA5, 16'd0, LEVEL_LOW));
        send_item(make_tick());
        send_item(make_command(MODE_OFF, 8'hFF, 8'hFF, 8'hFF, 16'd1, LEVEL_HIGH));
        send_item(make_tick());
        send_item(make_command(MODE_BLINK, 8'h12, 8'h34, 8'h56, 16'd2, LEVEL_MEDIUM));
        repeat (2) send_item(make_tick());
        send_item(make_command(MODE_BREATHE, 8'hFF, 8'h80, 8'h01, 16'd1, LEVEL_DEFAULT));
        send_item(make_tick());
        send_item(make_command(MODE_BREATHE, 8'hFF, 8'hFF, 8'hFF, 16'd4, LEVEL_HIGH));
        repeat (4) send_item(make_tick());
        send_item(make_command(MODE_BREATHE, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF, LEVEL_MEDIUM));
        send_item(make_tick());
    endtask

    task automatic test_brightness_levels();
        t_fx_settings       s;
        logic [LEVEL_W-1:0] levels [4];
        levels = '{LEVEL_DEFAULT, LEVEL_LOW, LEVEL_MEDIUM, LEVEL_HIGH};
        s = '{8'd11, 8'd22, 8'd33, 8'd44, LEVEL_DEFAULT, 8'd1};
        apply_settings(s);
        send_item(make_command(MODE_SOLID, 8'h5A, 8'hA5, 8'hFF, 16'd10, LEVEL_DEFAULT));
        foreach (levels[k]) begin
            s.global_level = levels[k];
            apply_settings(s);
            send_item(make_tick());
        end
    endtask

    task automatic test_frame_interval_edges();
        t_fx_settings s;
        s = '{8'd64, 8'd128, 8'd255, 8'd128, LEVEL_HIGH, 8'd255};
        apply_settings(s);
        send_item(make_command(MODE_SOLID, 8'h81, 8'h42, 8'h24, 16'd7, LEVEL_HIGH));
        repeat (6) send_item(make_tick());
        // The frame counter is now past the new interval, so the next tick renders.
        s.frame_interval = 8'd3;
        apply_settings(s);
        send_item(make_tick());
        s.frame_interval = 8'd0;
        apply_settings(s);
        repeat (2) send_item(make_tick());
        wait_block_idle();
        write_reg(REG_SPARE_A, 8'hFF);
        write_reg(REG_SPARE_B, 8'h00);
        i_cfg_valid <= 1'b0;
        send_item(make_tick());
    endtask

    task automatic test_output_backpressure();
        apply_settings('{8'd64, 8'd128, 8'd255, 8'd128, LEVEL_MEDIUM, 8'd1});
        src_gaps_on = 1'b0;
        send_item(make_command(MODE_BREATHE, 8'hFF, 8'h80, 8'h3C, 16'd16, LEVEL_DEFAULT));
        sink_hold_req = 200;
        repeat (40) send_item(make_tick());
        wait_frames_drained();
        src_gaps_on = 1'b1;
        repeat (20) send_item(make_tick());
        wait_frames_drained();
    endtask

    task automatic test_random_traffic();
        int sent;
        int phase;
        int quota;
        int done;
        int burst;
        sent  = 0;
        phase = 0;
        while (sent < RANDOM_ITEMS) begin
            apply_settings(random_settings(phase));
            src_gaps_on    = ($urandom_range(0, 3) != 0);
            sink_stalls_on = ($urandom_range(0, 3) != 0);
            quota = $urandom_range(60, 160);
            done  = 0;
            while (done < quota) begin
                if ($urandom_range(0, 9) < 8) begin
                    send_item(random_command());
                    burst = $urandom_range(1, 40);
                    repeat (burst) send_item(make_tick());
                    done += burst + 1;
                end else begin
                    if ($urandom_range(0, 1) != 0) send_item(random_command());
                    else send_item(make_tick());
                    done++;
                end
                if ($urandom_range(0, 29) == 0) wait_frames_drained();
            end
            sent += done;
            phase++;
        end
        src_gaps_on    = 1'b1;
        sink_stalls_on = 1'b1;
    endtask

    initial begin : frame_sink_pacing
        int stall_left;
        int hold_left;
        stall_left = 0;
        hold_left  = 0;
        fx_out.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (sink_hold_req > 0) begin
                hold_left     = sink_hold_req;
                sink_hold_req = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                fx_out.ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                fx_out.ready <= 1'b0;
            end else if (sink_stalls_on && $urandom_range(0, 99) < 25) begin
                stall_left = idle_length() - 1;
                fx_out.ready <= 1'b0;
            end else begin
                fx_out.ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        t_frame want;
        if (i_rst_n && fx_out.valid === 1'b1 && fx_out.ready === 1'b1) begin
            if (frames_due.size() == 0) begin
                $error("frame transfer with no frame expected");
                error_count++;
            end else begin
                want = frames_due.pop_front();
                frames_checked++;
                if (fx_out.frame_mode !== want.frame_mode) begin
                    $error("frame_mode mismatch: expected %0d, actual %0d",
                           want.frame_mode, fx_out.frame_mode);
                    error_count++;
                end
                if (fx_out.out_red !== want.out_red) begin
                    $error("out_red mismatch: expected %0d, actual %0d",
                           want.out_red, fx_out.out_red);
                    error_count++;
                end
                if (fx_out.out_green !== want.out_green) begin
                    $error("out_green mismatch: expected %0d, actual %0d",
                           want.out_green, fx_out.out_green);
                    error_count++;
                end
                if (fx_out.out_blue !== want.out_blue) begin
                    $error("out_blue mismatch: expected %0d, actual %0d",
                           want.out_blue, fx_out.out_blue);
                    error_count++;
                end
                if (fx_out.strip_brightness !== want.strip_brightness) begin
                    $error("strip_brightness mismatch: expected %0d, actual %0d",
                           want.strip_brightness, fx_out.strip_brightness);
                    error_count++;
                end
            end
        end
    end

    initial begin : stimulus
        int waited;
        i_rst_n          <= 1'b0;
        fx_in.valid      <= 1'b0;
        fx_in.op         <= OP_TICK;
        fx_in.mode       <= MODE_OFF;
        fx_in.red        <= '0;
        fx_in.green      <= '0;
        fx_in.blue       <= '0;
        fx_in.period_len <= '0;
        fx_in.level      <= LEVEL_DEFAULT;
        i_cfg_valid      <= 1'b0;
        i_cfg_index      <= REG_LOW_BRIGHTNESS;
        i_cfg_data       <= '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_frame();
        test_render_modes();
        test_brightness_levels();
        test_frame_interval_edges();
        test_output_backpressure();
        test_random_traffic();

        fx_in.valid <= 1'b0;
        waited = 0;
        while (frames_due.size() != 0 && waited < END_WAIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (IDLE_SETTLE) @(posedge i_clk);
        if (frames_due.size() != 0) begin
            $error("%0d expected frames never arrived", frames_due.size());
            error_count += frames_due.size();
        end
        $display("Run covered %0d command and %0d tick transfers, %0d frames checked.",
                 commands_sent, ticks_sent, frames_checked);
        $display("All modes and levels were rendered under %0d register settings.",
                 settings_loaded);
        if (error_count == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end

endmodule
